>>> rtl/quaternion_slerp_top_defines.svh
// Assertion macros used by the top-level RTL file of the slerp block.
`ifndef QUATERNION_SLERP_TOP_DEFINES_SVH
`define QUATERNION_SLERP_TOP_DEFINES_SVH
`ifndef SYNTH
`define QS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("slerp assertion failed (same cycle)");
`define QS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("slerp assertion failed (next cycle)");
`else
`define QS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define QS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/slerp_pkg.sv
`default_nettype none
package slerp_pkg;

    localparam int IN_W    = 16;
    localparam int THR_W   = 31;
    localparam int DC_W    = 31;
    localparam int RAD_W   = 61;
    localparam int ROOT_W  = 31;
    localparam int CX_W    = 34;
    localparam int Z_W     = 19;
    localparam int THETA_W = 17;
    localparam int P_W     = 18;
    localparam int W_W     = 34;
    localparam int PR_W    = 50;
    localparam int ATAN_N  = 16;

    localparam logic [THR_W-1:0]      THR_RESET = 31'd1073634450;
    localparam logic [IN_W-1:0]       BLEND_ONE = 16'd32768;
    localparam logic [DC_W-1:0]       ONE_Q30   = 31'h4000_0000;
    localparam logic [RAD_W-1:0]      ONE_Q60   = 61'h1000_0000_0000_0000;
    localparam logic signed [CX_W-1:0] INV_GAIN = 34'sd652032874;

    // Arctangent of 2^-i in radians, Q.16.
    localparam logic [15:0] ATAN_Q16 [ATAN_N] = '{
        16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
        16'd256, 16'd128, 16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2
    };

    typedef struct packed {
        logic signed [IN_W-1:0] a_x;
        logic signed [IN_W-1:0] a_y;
        logic signed [IN_W-1:0] a_z;
        logic signed [IN_W-1:0] a_w;
        logic signed [IN_W-1:0] b_x;
        logic signed [IN_W-1:0] b_y;
        logic signed [IN_W-1:0] b_z;
        logic signed [IN_W-1:0] b_w;
        logic [IN_W-1:0]        blend;
    } t_in;

    typedef struct packed {
        logic signed [IN_W-1:0] r_x;
        logic signed [IN_W-1:0] r_y;
        logic signed [IN_W-1:0] r_z;
        logic signed [IN_W-1:0] r_w;
        logic                   linear_used;
    } t_out;

    // Operands and flags that ride along the trigonometry pipeline.
    typedef struct packed {
        logic [3:0][IN_W-1:0] qa;
        logic [3:0][IN_W-1:0] qb;
        logic [IN_W-1:0]      blend;
        logic                 lin;
        logic                 neg;
    } t_side;

endpackage
`default_nettype wire

>>> rtl/slerp_sqrt.sv
`default_nettype none
module slerp_sqrt #(
    parameter int SB_W = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [slerp_pkg::RAD_W-1:0]    i_rad,
    input  logic [SB_W-1:0]                i_sb,
    output logic                           o_valid,
    output logic [slerp_pkg::ROOT_W-1:0]   o_root,
    output logic [SB_W-1:0]                o_sb
);
    import slerp_pkg::*;

    localparam int STEPS = ROOT_W;
    localparam int V_W   = RAD_W + 1;

    logic [V_W-1:0]  r_v   [STEPS];
    logic [V_W-1:0]  r_r   [STEPS];
    logic            r_vld [STEPS];
    logic [SB_W-1:0] r_sb  [STEPS];

    // One result bit per stage, digit by digit from the top pair of bits.
    for (genvar g = 0; g < STEPS; g++) begin : g_step
        localparam logic [V_W-1:0] BIT = V_W'(1) << (2 * (STEPS - 1 - g));
        logic [V_W-1:0]  v_in;
        logic [V_W-1:0]  q_in;
        logic            vld_in;
        logic [SB_W-1:0] sb_in;
        logic [V_W-1:0]  cand;
        logic [V_W-1:0]  n_v;
        logic [V_W-1:0]  n_r;

        if (g == 0) begin : g_first
            assign v_in   = {1'b0, i_rad};
            assign q_in   = '0;
            assign vld_in = i_valid;
            assign sb_in  = i_sb;
        end else begin : g_next
            assign v_in   = r_v[g-1];
            assign q_in   = r_r[g-1];
            assign vld_in = r_vld[g-1];
            assign sb_in  = r_sb[g-1];
        end

        always_comb begin
            cand = q_in + BIT;
            if (v_in >= cand) begin
                n_v = v_in - cand;
                n_r = (q_in >> 1) + BIT;
            end else begin
                n_v = v_in;
                n_r = q_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[g]  <= n_v;
                r_r[g]  <= n_r;
                r_sb[g] <= sb_in;
            end
        end
    end

    assign o_valid = r_vld[STEPS-1];
    assign o_root  = r_r[STEPS-1][ROOT_W-1:0];
    assign o_sb    = r_sb[STEPS-1];

endmodule
`default_nettype wire

>>> rtl/slerp_vec.sv
`default_nettype none
module slerp_vec #(
    parameter int STEPS = 12,
    parameter int SB_W  = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [slerp_pkg::DC_W-1:0]      i_x,
    input  logic [slerp_pkg::ROOT_W-1:0]    i_y,
    input  logic [SB_W-1:0]                 i_sb,
    output logic                            o_valid,
    output logic [slerp_pkg::THETA_W-1:0]   o_theta,
    output logic [SB_W-1:0]                 o_sb
);
    import slerp_pkg::*;

    logic signed [CX_W-1:0] r_x   [STEPS];
    logic signed [CX_W-1:0] r_y   [STEPS];
    logic signed [Z_W-1:0]  r_z   [STEPS];
    logic                   r_vld [STEPS];
    logic [SB_W-1:0]        r_sb  [STEPS];

    // Vectoring rotations drive y toward zero and collect the angle.
    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic signed [CX_W-1:0] x_in;
        logic signed [CX_W-1:0] y_in;
        logic signed [Z_W-1:0]  z_in;
        logic                   vld_in;
        logic [SB_W-1:0]        sb_in;
        logic signed [Z_W-1:0]  ang;
        logic signed [CX_W-1:0] n_x;
        logic signed [CX_W-1:0] n_y;
        logic signed [Z_W-1:0]  n_z;

        if (g == 0) begin : g_first
            assign x_in   = $signed(CX_W'(i_x));
            assign y_in   = $signed(CX_W'(i_y));
            assign z_in   = '0;
            assign vld_in = i_valid;
            assign sb_in  = i_sb;
        end else begin : g_next
            assign x_in   = r_x[g-1];
            assign y_in   = r_y[g-1];
            assign z_in   = r_z[g-1];
            assign vld_in = r_vld[g-1];
            assign sb_in  = r_sb[g-1];
        end

        assign ang = $signed({{(Z_W - 16){1'b0}}, ATAN_Q16[g]});

        always_comb begin
            if (y_in > 0) begin
                n_x = x_in + (y_in >>> g);
                n_y = y_in - (x_in >>> g);
                n_z = z_in + ang;
            end else begin
                n_x = x_in - (y_in >>> g);
                n_y = y_in + (x_in >>> g);
                n_z = z_in - ang;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g]  <= n_x;
                r_y[g]  <= n_y;
                r_z[g]  <= n_z;
                r_sb[g] <= sb_in;
            end
        end
    end

    // A negative angle is clamped to zero.
    assign o_theta = r_z[STEPS-1][Z_W-1] ? '0 : r_z[STEPS-1][THETA_W-1:0];
    assign o_valid = r_vld[STEPS-1];
    assign o_sb    = r_sb[STEPS-1];

endmodule
`default_nettype wire

>>> rtl/slerp_rot.sv
`default_nettype none
module slerp_rot #(
    parameter int STEPS = 12,
    parameter int SB_W  = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [slerp_pkg::P_W-1:0]         i_z0,
    input  logic [slerp_pkg::P_W-1:0]         i_z1,
    input  logic [SB_W-1:0]                   i_sb,
    output logic                              o_valid,
    output logic signed [slerp_pkg::CX_W-1:0] o_y0,
    output logic signed [slerp_pkg::CX_W-1:0] o_y1,
    output logic [SB_W-1:0]                   o_sb
);
    import slerp_pkg::*;

    localparam int LANES = 2;

    logic signed [CX_W-1:0] r_x   [STEPS][LANES];
    logic signed [CX_W-1:0] r_y   [STEPS][LANES];
    logic signed [Z_W-1:0]  r_z   [STEPS][LANES];
    logic                   r_vld [STEPS];
    logic [SB_W-1:0]        r_sb  [STEPS];
    logic [P_W-1:0]         z_init [LANES];

    assign z_init[0] = i_z0;
    assign z_init[1] = i_z1;

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic signed [Z_W-1:0] ang;
        logic                  vld_in;
        logic [SB_W-1:0]       sb_in;

        assign ang = $signed({{(Z_W - 16){1'b0}}, ATAN_Q16[g]});

        if (g == 0) begin : g_first
            assign vld_in = i_valid;
            assign sb_in  = i_sb;
        end else begin : g_next
            assign vld_in = r_vld[g-1];
            assign sb_in  = r_sb[g-1];
        end

        // Both sines share the step count; each lane rotates its own angle.
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic signed [CX_W-1:0] x_in;
            logic signed [CX_W-1:0] y_in;
            logic signed [Z_W-1:0]  z_in;
            logic signed [CX_W-1:0] n_x;
            logic signed [CX_W-1:0] n_y;
            logic signed [Z_W-1:0]  n_z;

            if (g == 0) begin : g_first
                assign x_in = INV_GAIN;
                assign y_in = '0;
                assign z_in = $signed({1'b0, z_init[l]});
            end else begin : g_next
                assign x_in = r_x[g-1][l];
                assign y_in = r_y[g-1][l];
                assign z_in = r_z[g-1][l];
            end

            always_comb begin
                if (z_in >= 0) begin
                    n_x = x_in - (y_in >>> g);
                    n_y = y_in + (x_in >>> g);
                    n_z = z_in - ang;
                end else begin
                    n_x = x_in + (y_in >>> g);
                    n_y = y_in - (x_in >>> g);
                    n_z = z_in + ang;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[g][l] <= n_x;
                    r_y[g][l] <= n_y;
                    r_z[g][l] <= n_z;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sb[g] <= sb_in;
            end
        end
    end

    assign o_valid = r_vld[STEPS-1];
    assign o_y0    = r_y[STEPS-1][0];
    assign o_y1    = r_y[STEPS-1][1];
    assign o_sb    = r_sb[STEPS-1];

endmodule
`default_nettype wire

>>> rtl/slerp_div.sv
`default_nettype none
module slerp_div #(
    parameter int SB_W = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [slerp_pkg::CX_W-1:0] i_num0,
    input  logic signed [slerp_pkg::CX_W-1:0] i_num1,
    input  logic [slerp_pkg::ROOT_W-1:0]      i_den,
    input  logic [SB_W-1:0]                   i_sb,
    output logic                              o_valid,
    output logic signed [slerp_pkg::W_W-1:0]  o_w0,
    output logic signed [slerp_pkg::W_W-1:0]  o_w1,
    output logic [SB_W-1:0]                   o_sb
);
    import slerp_pkg::*;

    localparam int LANES = 2;
    localparam int Q_W   = 35;
    localparam int FRAC  = 30;
    localparam int LOW_W = Q_W - FRAC;
    localparam int REM_W = ROOT_W + 1;
    localparam int MAG_W = CX_W;
    localparam logic [Q_W-1:0] QMAX = Q_W'(1) << 32;

    logic signed [CX_W-1:0] num [LANES];
    assign num[0] = i_num0;
    assign num[1] = i_num1;

    // Front stage: magnitude, sign, overflow and zero-divisor checks.
    logic                r_p_vld;
    logic [ROOT_W-1:0]   r_p_den;
    logic [SB_W-1:0]     r_p_sb;
    logic                r_p_zero;
    logic [REM_W-1:0]    r_p_rem [LANES];
    logic [LOW_W-1:0]    r_p_low [LANES];
    logic                r_p_ovf [LANES];
    logic                r_p_neg [LANES];

    for (genvar l = 0; l < LANES; l++) begin : g_pre
        logic [MAG_W-1:0] mag;
        assign mag = num[l][CX_W-1] ? MAG_W'(-num[l]) : MAG_W'(num[l]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p_rem[l] <= REM_W'(mag >> LOW_W);
                r_p_low[l] <= mag[LOW_W-1:0];
                r_p_ovf[l] <= {2'b00, mag} >= {i_den, {LOW_W{1'b0}}};
                r_p_neg[l] <= num[l][CX_W-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (i_en) begin
            r_p_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_den  <= i_den;
            r_p_sb   <= i_sb;
            r_p_zero <= (i_den == '0);
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    logic              r_s_vld  [Q_W];
    logic [ROOT_W-1:0] r_s_den  [Q_W];
    logic [SB_W-1:0]   r_s_sb   [Q_W];
    logic              r_s_zero [Q_W];
    logic [REM_W-1:0]  r_s_rem  [Q_W][LANES];
    logic [Q_W-1:0]    r_s_q    [Q_W][LANES];
    logic [LOW_W-1:0]  r_s_low  [Q_W][LANES];
    logic              r_s_ovf  [Q_W][LANES];
    logic              r_s_neg  [Q_W][LANES];

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        localparam int J = Q_W - 1 - k;
        logic              vld_in;
        logic [ROOT_W-1:0] den_in;
        logic [SB_W-1:0]   sb_in;
        logic              zero_in;

        if (k == 0) begin : g_first
            assign vld_in  = r_p_vld;
            assign den_in  = r_p_den;
            assign sb_in   = r_p_sb;
            assign zero_in = r_p_zero;
        end else begin : g_next
            assign vld_in  = r_s_vld[k-1];
            assign den_in  = r_s_den[k-1];
            assign sb_in   = r_s_sb[k-1];
            assign zero_in = r_s_zero[k-1];
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [REM_W-1:0] rem_in;
            logic [Q_W-1:0]   q_in;
            logic [LOW_W-1:0] low_in;
            logic             ovf_in;
            logic             neg_in;
            logic             nb;
            logic [REM_W-1:0] rem_sh;
            logic             ge;
            logic [REM_W-1:0] n_rem;
            logic [Q_W-1:0]   n_q;

            if (k == 0) begin : g_first
                assign rem_in = r_p_rem[l];
                assign q_in   = '0;
                assign low_in = r_p_low[l];
                assign ovf_in = r_p_ovf[l];
                assign neg_in = r_p_neg[l];
            end else begin : g_next
                assign rem_in = r_s_rem[k-1][l];
                assign q_in   = r_s_q[k-1][l];
                assign low_in = r_s_low[k-1][l];
                assign ovf_in = r_s_ovf[k-1][l];
                assign neg_in = r_s_neg[k-1][l];
            end

            if (J >= FRAC) begin : g_num_bit
                assign nb = low_in[J-FRAC];
            end else begin : g_zero_bit
                assign nb = 1'b0;
            end

            always_comb begin
                rem_sh = {rem_in[REM_W-2:0], nb};
                ge     = rem_sh >= {1'b0, den_in};
                n_rem  = ge ? rem_sh - {1'b0, den_in} : rem_sh;
                n_q    = q_in;
                n_q[J] = ge;
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_s_rem[k][l] <= n_rem;
                    r_s_q[k][l]   <= n_q;
                    r_s_low[k][l] <= low_in;
                    r_s_ovf[k][l] <= ovf_in;
                    r_s_neg[k][l] <= neg_in;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_s_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s_den[k]  <= den_in;
                r_s_sb[k]   <= sb_in;
                r_s_zero[k] <= zero_in;
            end
        end
    end

    // Back stage: saturate to plus or minus 2^32, restore the sign, zero on a zero divisor.
    logic                  r_o_vld;
    logic [SB_W-1:0]       r_o_sb;
    logic signed [W_W-1:0] r_o_w [LANES];

    for (genvar l = 0; l < LANES; l++) begin : g_post
        logic [Q_W-1:0]        m;
        logic signed [W_W-1:0] n_w;
        always_comb begin
            m = (r_s_ovf[Q_W-1][l] || (r_s_q[Q_W-1][l] > QMAX)) ? QMAX : r_s_q[Q_W-1][l];
            if (r_s_zero[Q_W-1]) begin
                n_w = '0;
            end else if (r_s_neg[Q_W-1][l]) begin
                n_w = -$signed(W_W'(m));
            end else begin
                n_w = $signed(W_W'(m));
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_o_w[l] <= n_w;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_s_vld[Q_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_sb <= r_s_sb[Q_W-1];
        end
    end

    assign o_valid = r_o_vld;
    assign o_w0    = r_o_w[0];
    assign o_w1    = r_o_w[1];
    assign o_sb    = r_o_sb;

endmodule
`default_nettype wire

>>> rtl/quaternion_slerp_top.sv
// Quaternion slerp, fully pipelined: one transaction accepted per cycle
// while the skid register is empty; the pipeline freezes while it is full.
// Most of the depth comes from the 31-stage square root and the 37-stage
// weight divider.
// Reset is synchronous, active low: it empties the pipeline and the output
// stages and loads the threshold register with its reset value.
`default_nettype none
`include "quaternion_slerp_top_defines.svh"
module quaternion_slerp_top #(
    parameter int ANGLE_TABLE_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  slerp_pkg::t_in                i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output slerp_pkg::t_out               o_out_data,
    input  logic                          i_cfg_we,
    input  logic [slerp_pkg::THR_W-1:0]   i_cfg_data
);
    import slerp_pkg::*;

    // Number of CORDIC micro-rotations in both the angle and the sine units.
    localparam int STEPS  = (ANGLE_TABLE_BITS + 2 > ATAN_N) ? ATAN_N : ANGLE_TABLE_BITS + 2;
    localparam int SIDE_W = $bits(t_side);

    // The whole pipeline advances together. It only freezes when the skid
    // register holds a transaction, which happens after the output register
    // was stalled while another result arrived. Because the freeze comes from
    // a register, the input ready has no combinational path from i_out_ready.
    logic en;
    logic r_skid_vld;
    assign en         = !r_skid_vld;
    assign o_in_ready = en;

    // Threshold register; the user must write it only while the block is idle, the block does not enforce this.
    logic [THR_W-1:0] r_thr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    // Stage 1: four component products of the dot product, blend clamped to one.
    logic                    in_take;
    logic                    r1_vld;
    t_side                   r1_side;
    t_side                   n1_side;
    logic signed [2*IN_W-1:0] r1_prod [4];

    assign in_take = i_in_valid && en;

    always_comb begin
        n1_side.qa    = {i_in_data.a_w, i_in_data.a_z, i_in_data.a_y, i_in_data.a_x};
        n1_side.qb    = {i_in_data.b_w, i_in_data.b_z, i_in_data.b_y, i_in_data.b_x};
        n1_side.blend = (i_in_data.blend > BLEND_ONE) ? BLEND_ONE : i_in_data.blend;
        n1_side.lin   = 1'b0;
        n1_side.neg   = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_side    <= n1_side;
            r1_prod[0] <= i_in_data.a_x * i_in_data.b_x;
            r1_prod[1] <= i_in_data.a_y * i_in_data.b_y;
            r1_prod[2] <= i_in_data.a_z * i_in_data.b_z;
            r1_prod[3] <= i_in_data.a_w * i_in_data.b_w;
        end
    end

    // Stage 2: dot product in Q2.30, short-arc sign, linear decision and
    // the clamp of |d| to one for the trigonometry.
    logic signed [2*IN_W+1:0] n_sum;
    logic signed [2*IN_W+3:0] n_d;
    logic [2*IN_W+2:0]        n_ad;
    logic                     n_neg;
    t_side                    n2_side;
    logic                     r2_vld;
    t_side                    r2_side;
    logic [DC_W-1:0]          r2_dc;

    always_comb begin
        n_sum = (2*IN_W+2)'(r1_prod[0]) + (2*IN_W+2)'(r1_prod[1])
              + (2*IN_W+2)'(r1_prod[2]) + (2*IN_W+2)'(r1_prod[3]);
        n_d   = $signed({n_sum, 2'b00});
        n_neg = n_d[2*IN_W+3];
        n_ad  = n_neg ? (2*IN_W+3)'(-n_d) : (2*IN_W+3)'(n_d);
        n2_side     = r1_side;
        n2_side.neg = n_neg;
        n2_side.lin = n_ad > (2*IN_W+3)'(r_thr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_side <= n2_side;
            r2_dc   <= (n_ad > (2*IN_W+3)'(ONE_Q30)) ? ONE_Q30 : n_ad[DC_W-1:0];
        end
    end

    // Stage 3: square of the clamped dot product.
    logic                r3_vld;
    t_side               r3_side;
    logic [DC_W-1:0]     r3_dc;
    logic [2*DC_W-1:0]   r3_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_side <= r2_side;
            r3_dc   <= r2_dc;
            r3_sq   <= r2_dc * r2_dc;
        end
    end

    // Stage 4: radicand 1 - d^2 in Q4.60.
    logic                r4_vld;
    t_side               r4_side;
    logic [DC_W-1:0]     r4_dc;
    logic [RAD_W-1:0]    r4_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_side <= r3_side;
            r4_dc   <= r3_dc;
            r4_rad  <= ONE_Q60 - RAD_W'(r3_sq);
        end
    end

    // sin(theta) = floor(sqrt(1 - d^2)) in Q2.30.
    logic                     sq_vld;
    logic [ROOT_W-1:0]        sq_root;
    logic [DC_W+SIDE_W-1:0]   sq_sb;
    logic [DC_W-1:0]          sq_dc;
    t_side                    sq_side;

    slerp_sqrt #(
        .SB_W (DC_W + SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_vld),
        .i_rad   (r4_rad),
        .i_sb    ({r4_dc, r4_side}),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_sb    (sq_sb)
    );

    assign {sq_dc, sq_side} = sq_sb;

    // theta = atan2(sin, cos) by vectoring rotations.
    logic                      vc_vld;
    logic [THETA_W-1:0]        vc_theta;
    logic [ROOT_W+SIDE_W-1:0]  vc_sb;
    logic [ROOT_W-1:0]         vc_s;
    t_side                     vc_side;

    slerp_vec #(
        .STEPS (STEPS),
        .SB_W  (ROOT_W + SIDE_W)
    ) u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_vld),
        .i_x     (sq_dc),
        .i_y     (sq_root),
        .i_sb    ({sq_root, sq_side}),
        .o_valid (vc_vld),
        .o_theta (vc_theta),
        .o_sb    (vc_sb)
    );

    assign {vc_s, vc_side} = vc_sb;

    // Stage 5: partial angles (1 - t) * theta and t * theta.
    logic                r5_vld;
    t_side               r5_side;
    logic [ROOT_W-1:0]   r5_s;
    logic [P_W-1:0]      r5_p0;
    logic [P_W-1:0]      r5_p1;
    logic [IN_W-1:0]     omt5;
    logic [IN_W+THETA_W-1:0] n_pp0;
    logic [IN_W+THETA_W-1:0] n_pp1;

    always_comb begin
        omt5  = BLEND_ONE - vc_side.blend;
        n_pp0 = (IN_W+THETA_W)'(omt5) * (IN_W+THETA_W)'(vc_theta);
        n_pp1 = (IN_W+THETA_W)'(vc_side.blend) * (IN_W+THETA_W)'(vc_theta);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= vc_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_side <= vc_side;
            r5_s    <= vc_s;
            r5_p0   <= n_pp0[IN_W-1+P_W-1:IN_W-1];
            r5_p1   <= n_pp1[IN_W-1+P_W-1:IN_W-1];
        end
    end

    // Sines of both partial angles.
    logic                      rt_vld;
    logic signed [CX_W-1:0]    rt_y0;
    logic signed [CX_W-1:0]    rt_y1;
    logic [ROOT_W+SIDE_W-1:0]  rt_sb;
    logic [ROOT_W-1:0]         rt_s;
    t_side                     rt_side;

    slerp_rot #(
        .STEPS (STEPS),
        .SB_W  (ROOT_W + SIDE_W)
    ) u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_vld),
        .i_z0    (r5_p0),
        .i_z1    (r5_p1),
        .i_sb    ({r5_s, r5_side}),
        .o_valid (rt_vld),
        .o_y0    (rt_y0),
        .o_y1    (rt_y1),
        .o_sb    (rt_sb)
    );

    assign {rt_s, rt_side} = rt_sb;

    // Slerp weights sin(phi) / sin(theta) in Q2.30.
    logic                  dv_vld;
    logic signed [W_W-1:0] dv_w0;
    logic signed [W_W-1:0] dv_w1;
    logic [SIDE_W-1:0]     dv_sb;
    t_side                 dv_side;

    slerp_div #(
        .SB_W (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rt_vld),
        .i_num0  (rt_y0),
        .i_num1  (rt_y1),
        .i_den   (rt_s),
        .i_sb    (rt_side),
        .o_valid (dv_vld),
        .o_w0    (dv_w0),
        .o_w1    (dv_w1),
        .o_sb    (dv_sb)
    );

    assign dv_side = dv_sb;

    // Stage 6: choose linear or slerp weights, negate the second one for the
    // short arc.
    logic                  r6_vld;
    t_side                 r6_side;
    logic signed [W_W-1:0] r6_w0;
    logic signed [W_W-1:0] r6_w1;
    logic [IN_W-1:0]       omt6;
    logic signed [W_W-1:0] n_w0;
    logic signed [W_W-1:0] n_w1;

    always_comb begin
        omt6 = BLEND_ONE - dv_side.blend;
        if (dv_side.lin) begin
            n_w0 = $signed({{(W_W-IN_W-15){1'b0}}, omt6, 15'd0});
            n_w1 = $signed({{(W_W-IN_W-15){1'b0}}, dv_side.blend, 15'd0});
        end else begin
            n_w0 = dv_w0;
            n_w1 = dv_w1;
        end
        if (dv_side.neg) begin
            n_w1 = -n_w1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_side <= dv_side;
            r6_w0   <= n_w0;
            r6_w1   <= n_w1;
        end
    end

    // Stage 7: weighted components, one multiplier per term.
    logic                   r7_vld;
    logic                   r7_lin;
    logic signed [PR_W-1:0] r7_pa [4];
    logic signed [PR_W-1:0] r7_pb [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (en) begin
            r7_vld <= r6_vld;
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_mul
        always_ff @(posedge i_clk) begin
            if (en) begin
                r7_pa[k] <= r6_w0 * $signed(r6_side.qa[k]);
                r7_pb[k] <= r6_w1 * $signed(r6_side.qb[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_lin <= r6_side.lin;
        end
    end

    // Stage 8: round to nearest (ties up), back to Q2.14, saturate.
    localparam int SUM_W = PR_W + 2;
    localparam int SH_W  = SUM_W - 30;
    localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) << 29;
    localparam logic signed [SH_W-1:0]  SAT_HI = SH_W'(32767);
    localparam logic signed [SH_W-1:0]  SAT_LO = -SH_W'(32768);

    logic signed [IN_W-1:0] res [4];
    logic                   r8_vld;
    t_out                   r8_out;
    t_out                   n8_out;

    for (genvar k = 0; k < 4; k++) begin : g_round
        logic signed [SUM_W-1:0] acc;
        logic signed [SH_W-1:0]  sh;
        always_comb begin
            acc = SUM_W'(r7_pa[k]) + SUM_W'(r7_pb[k]) + RND;
            sh  = SH_W'(acc >>> 30);
            if (sh > SAT_HI) begin
                res[k] = 16'sh7fff;
            end else if (sh < SAT_LO) begin
                res[k] = -16'sh8000;
            end else begin
                res[k] = sh[IN_W-1:0];
            end
        end
    end

    always_comb begin
        n8_out.r_x         = res[0];
        n8_out.r_y         = res[1];
        n8_out.r_z         = res[2];
        n8_out.r_w         = res[3];
        n8_out.linear_used = r7_lin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (en) begin
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_out <= n8_out;
        end
    end

    // Output register plus one skid register. A result leaves the last
    // pipeline stage whenever the pipeline advances; if the output register
    // is still held by the sink, that result parks in the skid register and
    // the pipeline stops on the next cycle until the skid drains.
    logic r_out_vld;
    t_out r_out_data;
    t_out r_skid_data;
    logic pipe_push;
    logic out_free;

    assign pipe_push = en && r8_vld;
    assign out_free  = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_free) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= pipe_push;
            end
        end else if (pipe_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_vld) begin
                r_out_data <= r_skid_data;
            end else if (pipe_push) begin
                r_out_data <= r8_out;
            end
        end else if (pipe_push) begin
            r_skid_data <= r8_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    // A parked transaction always has an occupied output register in front.
    `QS_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_vld, r_out_vld)
    // The skid register only fills while the output is stalled.
    `QS_ASSERT_NXT(a_skid_only_on_stall, i_clk, i_rst_n, !r_skid_vld && out_free, !r_skid_vld)
    // A parked transaction keeps the output valid on the next cycle.
    `QS_ASSERT_NXT(a_skid_keeps_out, i_clk, i_rst_n, r_skid_vld, r_out_vld)

endmodule
`default_nettype wire

>>> tb/sv/quaternion_slerp_top_tb.sv
`default_nettype none
// Self-checking bench for the quaternion slerp pipeline.
// A scoreboard object predicts every result as soon as its input transaction
// is accepted, and compares each output transaction against the oldest
// prediction. The run walks through several threshold settings. It opens with
// a directed set of corner quaternions, then sends random near-coincident
// pairs mixed with raw noise, with random idling on both channels.
module quaternion_slerp_top_tb;
    import slerp_pkg::*;

    localparam int ANGLE_BITS = 10;
    localparam int STEPS = (ANGLE_BITS + 2 > 16) ? 16 : ANGLE_BITS + 2;
    localparam int LATENCY = 77 + 2 * STEPS;
    localparam int ITEMS_PER_PHASE = 225;
    localparam longint Q30 = longint'(1) << 30;
    localparam longint WLIM = longint'(1) << 32;

    // The scoreboard holds its own copy of the threshold register and a queue
    // of predicted slerp results, oldest first.
    class slerp_scoreboard;
        logic [THR_W-1:0] threshold;
        t_out             slerp_q[$];
        int               errors;

        function new();
            threshold = THR_RESET;
            errors = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned root, b;
            root = 0;
            b = longint'(1) << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= root + b) begin
                    v -= root + b;
                    root = (root >> 1) + b;
                end else begin
                    root >>= 1;
                end
                b >>= 2;
            end
            return root;
        endfunction

        // Vectoring pass: the angle whose cosine and sine are x and y.
        function longint arc_angle(longint x, longint y);
            longint z, dx, dy;
            z = 0;
            for (int i = 0; i < STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0) begin
                    x += dx; y -= dy; z += longint'(ATAN_Q16[i]);
                end else begin
                    x -= dx; y += dy; z -= longint'(ATAN_Q16[i]);
                end
            end
            return (z < 0) ? 0 : z;
        endfunction

        // Rotating pass from the gain-corrected unit vector.
        function longint rot_sine(longint z);
            longint x, y, dx, dy;
            x = longint'(INV_GAIN);
            y = 0;
            for (int i = 0; i < STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(ATAN_Q16[i]);
                end else begin
                    x += dx; y -= dy; z += longint'(ATAN_Q16[i]);
                end
            end
            return y;
        endfunction

        function longint weight(longint num, longint den);
            longint w;
            if (den <= 0) return 0;
            w = (num * Q30) / den;
            if (w > WLIM) w = WLIM;
            if (w < -WLIM) w = -WLIM;
            return w;
        endfunction

        function t_out predict_slerp(t_in q);
            longint av[4], bv[4];
            longint t, d, ad, dc, s, theta, w0, w1, r;
            bit neg, lin;
            t_out res;
            t = longint'(q.blend);
            if (t > 32768) t = 32768;
            av = '{longint'(q.a_x), longint'(q.a_y), longint'(q.a_z), longint'(q.a_w)};
            bv = '{longint'(q.b_x), longint'(q.b_y), longint'(q.b_z), longint'(q.b_w)};
            d = 0;
            for (int k = 0; k < 4; k++) d += av[k] * bv[k];
            d *= 4;
            neg = d < 0;
            ad = neg ? -d : d;
            lin = ad > longint'(threshold);
            if (lin) begin
                w0 = (32768 - t) * 32768;
                w1 = t * 32768;
            end else begin
                dc = (ad > Q30) ? Q30 : ad;
                s = longint'(int_sqrt(longint'(Q30 * Q30 - dc * dc)));
                theta = arc_angle(dc, s);
                w0 = weight(rot_sine(((32768 - t) * theta) >>> 15), s);
                w1 = weight(rot_sine((t * theta) >>> 15), s);
            end
            if (neg) w1 = -w1;
            for (int k = 0; k < 4; k++) begin
                r = (w0 * av[k] + w1 * bv[k] + (longint'(1) << 29)) >>> 30;
                if (r > 32767) r = 32767;
                if (r < -32768) r = -32768;
                case (k)
                    0: res.r_x = r[15:0];
                    1: res.r_y = r[15:0];
                    2: res.r_z = r[15:0];
                    default: res.r_w = r[15:0];
                endcase
            end
            res.linear_used = lin;
            return res;
        endfunction

        function void note_input(t_in q);
            slerp_q.push_back(predict_slerp(q));
        endfunction

        task check_result(t_out got);
            t_out want;
            if (slerp_q.size() == 0) begin
                report("result transaction with no prediction pending");
                return;
            end
            want = slerp_q.pop_front();
            if (got.r_x !== want.r_x)
                report($sformatf("r_x got %0d want %0d", got.r_x, want.r_x));
            if (got.r_y !== want.r_y)
                report($sformatf("r_y got %0d want %0d", got.r_y, want.r_y));
            if (got.r_z !== want.r_z)
                report($sformatf("r_z got %0d want %0d", got.r_z, want.r_z));
            if (got.r_w !== want.r_w)
                report($sformatf("r_w got %0d want %0d", got.r_w, want.r_w));
            if (got.linear_used !== want.linear_used)
                report($sformatf("linear_used got %b want %b",
                                 got.linear_used, want.linear_used));
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              in_valid;
    logic              in_ready;
    t_in               in_data;
    logic              out_valid;
    logic              out_ready;
    t_out              out_data;
    logic              cfg_we;
    logic [THR_W-1:0]  cfg_data;

    slerp_scoreboard sb;

    // When idling is off, both sides run back to back; hold_cycles requests
    // a long receiver stall that the receiver process counts down itself.
    bit idle_on;
    int hold_cycles;

    quaternion_slerp_top #(
        .ANGLE_TABLE_BITS(ANGLE_BITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the pipeline hangs.
    initial begin
        #2000000;
        $display("quaternion_slerp_top test failed");
        $finish;
    end

    // Receiver: every accepted transaction is checked, then a fresh random wait
    // is drawn when idling is on. The next ready value is settled first and then
    // assigned once, so ready never gets two updates in one time step.
    int  rx_wait;
    logic rx_next;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (out_valid && out_ready) begin
                sb.check_result(out_data);
                rx_wait = idle_on ? $urandom_range(0, 3) : 0;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                rx_next = 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                rx_next = 1'b0;
            end else begin
                rx_next = 1'b1;
            end
            out_ready <= rx_next;
        end
    end

    // Offers one input transaction and returns at the edge where it was
    // accepted. Called at a rising edge; valid stays high across back-to-back
    // transactions.
    task automatic send_item(t_in q);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        repeat (gap) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= q;
        do @(posedge i_clk); while (!in_ready);
        sb.note_input(q);
    endtask

    // The threshold is only written while the pipeline is empty.
    task automatic write_threshold(logic [THR_W-1:0] v);
        in_valid <= 1'b0;
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.threshold = v;
        @(posedge i_clk);
    endtask

    // Sender pause: waits until every predicted result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.slerp_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_in make_pair(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                                      logic [15:0] aw, logic [15:0] bx, logic [15:0] by,
                                      logic [15:0] bz, logic [15:0] bw, logic [15:0] t);
        t_in q;
        q.a_x = ax; q.a_y = ay; q.a_z = az; q.a_w = aw;
        q.b_x = bx; q.b_y = by; q.b_z = bz; q.b_w = bw;
        q.blend = t;
        return q;
    endfunction

    // Random item. Most are a random quaternion paired with a slightly
    // perturbed copy of itself, possibly negated, which exercises both the
    // linear and the trigonometric weights; the rest are raw noise.
    function automatic t_in random_item();
        t_in q;
        int sc, dbits, half;
        logic signed [15:0] a[4], b[4];
        bit flip;
        if ($urandom_range(0, 4) == 0) begin
            q = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
            return q;
        end
        sc = $urandom_range(0, 2) == 0 ? 32767 : 16384;
        dbits = $urandom_range(0, 14);
        half = (dbits == 0) ? 1 : (1 << (dbits - 1));
        flip = $urandom_range(0, 1);
        for (int k = 0; k < 4; k++) begin
            a[k] = 16'($signed($urandom_range(0, 2 * sc)) - sc);
            b[k] = 16'(a[k] + $signed($urandom_range(0, 1 << dbits)) - half);
            if (flip) b[k] = -b[k];
        end
        q.a_x = a[0]; q.a_y = a[1]; q.a_z = a[2]; q.a_w = a[3];
        q.b_x = b[0]; q.b_y = b[1]; q.b_z = b[2]; q.b_w = b[3];
        case ($urandom_range(0, 7))
            0: q.blend = 16'd0;
            1: q.blend = BLEND_ONE;
            2: q.blend = 16'($urandom_range(32769, 65535));
            default: q.blend = 16'($urandom_range(0, 32768));
        endcase
        return q;
    endfunction

    logic [THR_W-1:0] thr_list[6];

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        idle_on = 1'b1;
        hold_cycles = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed set under the reset threshold, then again with the top
        // threshold so that dots beyond one and a zero sine reach the trig
        // path instead of the linear one.
        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 1) write_threshold({THR_W{1'b1}});
            // All zero: zero dot, zero result.
            send_item(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 16384));
            // Identical unit quaternions at both blend ends and beyond one.
            send_item(make_pair(16384, 0, 0, 0, 16384, 0, 0, 0, 0));
            send_item(make_pair(16384, 0, 0, 0, 16384, 0, 0, 0, 16'd32768));
            send_item(make_pair(16384, 0, 0, 0, 16384, 0, 0, 0, 16'hFFFF));
            // Opposite quaternions take the short arc.
            send_item(make_pair(0, 16384, 0, 0, 0, 16'hC000, 0, 0, 8192));
            // Orthogonal pair, ninety degrees apart, then a pair sixty degrees apart.
            send_item(make_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 16384));
            send_item(make_pair(0, 0, 11585, 11585, 0, 11585, 0, 11585, 24576));
            // Field extremes: the dot runs far beyond one and outputs saturate.
            send_item(make_pair(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16384));
            send_item(make_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 100));
            send_item(make_pair(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                                16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF));
            // Dot a little above one, and near-coincident pairs.
            send_item(make_pair(16400, 0, 0, 0, 16400, 0, 0, 0, 5000));
            send_item(make_pair(16384, 0, 0, 0, 16383, 100, 0, 0, 20000));
            send_item(make_pair(16384, 0, 0, 0, 16380, 0, 300, 0, 1));
            drain();
        end

        // Threshold settings for the random phases, extremes included.
        thr_list = '{THR_RESET, '0, 31'h4000_0000, {THR_W{1'b1}},
                     31'd1073000000, '0};
        thr_list[5] = THR_W'($urandom_range(0, 32'h4000_0000));
        for (int ph = 0; ph < 6; ph++) begin
            write_threshold(thr_list[ph]);
            // In one phase the receiver stalls long enough for the pipeline
            // to fill and push back on the input side.
            if (ph == 2) hold_cycles = 400;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 40 == 0) idle_on = $urandom_range(0, 3) != 0;
                send_item(random_item());
            end
            idle_on = 1'b1;
            drain();
        end

        repeat (LATENCY + 20) @(posedge i_clk);
        if (sb.errors == 0 && sb.slerp_q.size() == 0) begin
            $display("quaternion_slerp_top test passed");
        end else begin
            $display("quaternion_slerp_top test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
